>>> src/kra_pkg.sv
// Shared types and constants for the key to register allocator.
`timescale 1ns / 1ps

package kra_pkg;

   // Request operation codes carried in req_tuser
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Register file layout
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_IDX_COUNT = 1'b0;
   localparam int CFG_W = 5;
   localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 5'd16;

   // Key store command from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

>>> src/kra_csr.sv
// Configuration register port and clamped register count.
`timescale 1ns / 1ps

module kra_csr #(
   parameter int MAX_REGS = 16,
   parameter int CNT_W    = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kra_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [kra_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [kra_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [CNT_W-1:0]                  reg_count
);

   logic [kra_pkg::CFG_W-1:0]     count_ff;
   logic [kra_pkg::CFG_W-1:0]     count_in;
   logic [kra_pkg::CSR_IDX_W-1:0] reg_idx;
   logic                          wr_hit;

   assign reg_idx    = csr_paddr[kra_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == kra_pkg::REG_IDX_COUNT);

   always_comb begin
      count_in = count_ff;
      if (wr_hit) begin
         count_in = csr_pwdata[kra_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= kra_pkg::CFG_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == kra_pkg::REG_IDX_COUNT) begin
         csr_prdata = kra_pkg::CSR_DATA_W'(count_ff);
      end
   end

   // Zero acts as one, anything above the table size acts as the table size
   always_comb begin
      priority if (count_ff == '0) begin
         reg_count = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_REGS)) begin
         reg_count = CNT_W'(MAX_REGS);
      end else begin
         reg_count = CNT_W'(count_ff);
      end
   end

endmodule

>>> src/kra_key_mem.sv
// Key store: one write port, one registered read port.
`timescale 1ns / 1ps

module kra_key_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  kra_pkg::mem_cmd_type cmd,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/kra_ctrl.sv
// Sequencer: key scan, modulo reduction and free-slot search on one compare unit.
`timescale 1ns / 1ps

module kra_ctrl #(
   parameter int MAX_REGS = 16,
   parameter int KEY_BITS = 32,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CNT_W-1:0]           reg_count,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [kra_pkg::OP_W-1:0]   req_op,
   input  logic [KEY_BITS-1:0]        req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [IDX_W-1:0]           rsp_idx,
   output logic                       rsp_ok,
   output kra_pkg::mem_cmd_type       mem_cmd,
   output logic [IDX_W-1:0]           mem_wr_addr,
   output logic [KEY_BITS-1:0]        mem_wr_data,
   output logic [IDX_W-1:0]           mem_rd_addr,
   input  logic [KEY_BITS-1:0]        mem_rd_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [kra_pkg::OP_W-1:0]  op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [MAX_REGS-1:0]       used_ff, used_in;
   logic [IDX_W-1:0]          nf_ff, nf_in;
   logic                      at_ff, at_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          steps_ff, steps_in;
   logic [IDX_W-1:0]          res_idx_ff, res_idx_in;
   logic                      res_ok_ff, res_ok_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic                      rsp_ok_ff, rsp_ok_in;

   logic                      hit_now;
   logic                      scan_end;
   logic                      issue;
   logic                      rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign issue     = (state_ff == ST_SCAN) && (scan_ff < CNT_W'(MAX_REGS));

   // Shared compare: stored key against the request key, one entry a cycle
   assign hit_now  = chk_vld_ff && used_ff[chk_idx_ff] && (mem_rd_data == key_ff);
   assign scan_end = hit_now || ((scan_ff == CNT_W'(MAX_REGS)) && !chk_vld_ff);
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_vld_ff || rsp_ready);

   assign mem_rd_addr = scan_ff[IDX_W-1:0];
   assign mem_wr_addr = nf_ff;
   assign mem_wr_data = key_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      used_in    = used_ff;
      nf_in      = nf_ff;
      at_in      = at_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      steps_in   = steps_ff;
      res_idx_in = res_idx_ff;
      res_ok_in  = res_ok_ff;
      mem_cmd.wr_en = 1'b0;
      mem_cmd.rd_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               key_in = req_key;
               if (req_op == kra_pkg::OP_CLEAR) begin
                  used_in    = '0;
                  nf_in      = '0;
                  at_in      = 1'b0;
                  res_idx_in = '0;
                  res_ok_in  = 1'b1;
                  state_in   = ST_RESULT;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               mem_cmd.rd_en = 1'b1;
               chk_vld_in    = 1'b1;
               chk_idx_in    = scan_ff[IDX_W-1:0];
               scan_in       = scan_ff + CNT_W'(1);
            end
            if (scan_end) begin
               chk_vld_in = 1'b0;
               res_idx_in = hit_now ? chk_idx_ff : '0;
               res_ok_in  = hit_now;
               state_in   = ST_RESULT;
               if (op_ff == kra_pkg::OP_REMOVE && hit_now) begin
                  used_in[chk_idx_ff] = 1'b0;
                  nf_in               = chk_idx_ff;
                  at_in               = 1'b0;
               end else if (op_ff == kra_pkg::OP_ADD) begin
                  // A key already present fails the add
                  res_idx_in = '0;
                  res_ok_in  = 1'b0;
                  if (!hit_now && !at_ff) begin
                     mem_cmd.wr_en  = 1'b1;
                     used_in[nf_ff] = 1'b1;
                     res_idx_in     = nf_ff;
                     res_ok_in      = 1'b1;
                     rem_in         = CNT_W'(nf_ff) + CNT_W'(1);
                     state_in       = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            // Reduce the search start below the register count
            if (rem_ff >= reg_count) begin
               rem_in = rem_ff - reg_count;
            end else begin
               pos_in   = rem_ff[IDX_W-1:0];
               steps_in = CNT_W'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (!used_ff[pos_ff]) begin
               nf_in    = pos_ff;
               state_in = ST_RESULT;
            end else if (steps_ff == reg_count) begin
               at_in    = 1'b1;
               state_in = ST_RESULT;
            end else begin
               pos_in   = ((CNT_W'(pos_ff) + CNT_W'(1)) == reg_count) ? '0
                          : pos_ff + IDX_W'(1);
               steps_in = steps_ff + CNT_W'(1);
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: hold the result until taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_ok_in  = rsp_ok_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
         rsp_idx_in = res_idx_ff;
         rsp_ok_in  = res_ok_ff;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chk_vld_ff <= 1'b0;
         used_ff    <= '0;
         nf_ff      <= '0;
         at_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         used_ff    <= used_in;
         nf_ff      <= nf_in;
         at_ff      <= at_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      steps_ff   <= steps_in;
      res_idx_ff <= res_idx_in;
      res_ok_ff  <= res_ok_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_idx   = rsp_idx_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule

>>> src/key_to_register_allocator_top.sv
// Top level of the key to register allocator.
//
// Channel  Direction  Accepted when                   Carries
// req      in         req_tvalid & req_tready         tdata: key; tuser: opcode
// rsp      out        rsp_tvalid & rsp_tready         tdata: register_index; tuser: ok
// csr      in         psel & penable & pwrite         register count at byte address 0
//
// Clear goes straight to the result state and then to the output register. Lookup and
// remove scan the key memory one entry per cycle through its registered read port.
// An add adds a reduction of the start index (one subtract per cycle) and a
// free-slot search over at most the register count entries.
// Reset is synchronous and frees all registers; req_tready is low while an item
// is in work, and a finished result waits in the output register for rsp_tready.
`timescale 1ns / 1ps

module key_to_register_allocator_top #(
   parameter int  MAX_REGS = 16,
   parameter int  KEY_BITS = 32,
   localparam int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
   localparam int CNT_W    = $clog2(MAX_REGS + 1),
   localparam int REQ_DW   = ((KEY_BITS + 7) / 8) * 8,
   localparam int RSP_DW   = ((IDX_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_DW-1:0]                 req_tdata,   // key
   input  logic [kra_pkg::OP_W-1:0]          req_tuser,   // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DW-1:0]                 rsp_tdata,   // register_index
   output logic                              rsp_tuser,   // ok
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kra_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [kra_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [kra_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [CNT_W-1:0]      reg_count;
   logic [IDX_W-1:0]      rsp_idx;
   kra_pkg::mem_cmd_type  mem_cmd;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [KEY_BITS-1:0]   mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [KEY_BITS-1:0]   mem_rd_data;

   kra_csr #(
      .MAX_REGS (MAX_REGS),
      .CNT_W    (CNT_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .reg_count   (reg_count)
   );

   kra_key_mem #(
      .DEPTH  (MAX_REGS),
      .WIDTH  (KEY_BITS),
      .ADDR_W (IDX_W)
   ) u_key_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   kra_ctrl #(
      .MAX_REGS (MAX_REGS),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .reg_count   (reg_count),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_key     (req_tdata[KEY_BITS-1:0]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_idx     (rsp_idx),
      .rsp_ok      (rsp_tuser),
      .mem_cmd     (mem_cmd),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   assign rsp_tdata = RSP_DW'(rsp_idx);

endmodule

>>> test/tb.sv
// Self-checking testbench for the key to register allocator.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_REGS      = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_ITEMS   = 250;
   localparam int PHASE_COUNT   = 6;
   localparam int CALM_ITEMS    = 200;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      logic [3:0] index;
      logic       ok;
   } alloc_result_type;

   typedef struct {
      bit                        is_cfg;
      logic [kra_pkg::CFG_W-1:0] count;
      logic [kra_pkg::OP_W-1:0]  op;
      logic [31:0]               key;
      bit                        typed;
      logic [3:0]                index;
      logic                      ok;
   } step_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [31:0]                    req_tdata;   // key
   logic [kra_pkg::OP_W-1:0]       req_tuser;   // opcode
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [7:0]                     rsp_tdata;   // register_index, zero padded
   logic                           rsp_tuser;   // ok
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [kra_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [kra_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [kra_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Shadow of the allocator state
   logic [31:0]               held_key [NUM_REGS];
   logic [NUM_REGS-1:0]       held_valid;
   logic [3:0]                free_ptr;
   logic                      map_full;
   logic [kra_pkg::CFG_W-1:0] reg_limit;

   alloc_result_type pending_results[$];
   step_row_type     directed_steps[$];
   logic [31:0]      key_pool[$];
   int               errors;
   int               cycles;
   int               stall_left;
   bit               calm;

   key_to_register_allocator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall bursts, none once calm
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding: register_index %0d ok %0b",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== {4'b0, want.index}) begin
               $error("register_index: expected %0d, actual %0d", want.index, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.ok) begin
               $error("ok: expected %0b, actual %0b", want.ok, rsp_tuser);
               errors++;
            end
         end
      end
   end

   function automatic int effective_count(input logic [kra_pkg::CFG_W-1:0] val);
      if (val == 0) return 1;
      if (val > NUM_REGS) return NUM_REGS;
      return int'(val);
   endfunction

   task automatic predict_allocation(input logic [kra_pkg::OP_W-1:0] op,
                                     input logic [31:0] key,
                                     output alloc_result_type res);
      int hit;
      int n;
      int c;
      int start;
      bit found;
      hit = -1;
      for (int i = 0; i < NUM_REGS; i++)
         if (hit < 0 && held_valid[i] && held_key[i] == key) hit = i;
      res.index = 4'd0;
      res.ok    = 1'b0;
      case (op)
         kra_pkg::OP_LOOKUP: begin
            if (hit >= 0) begin
               res.index = hit[3:0];
               res.ok    = 1'b1;
            end
         end
         kra_pkg::OP_ADD: begin
            if (!map_full && hit < 0) begin
               n     = effective_count(reg_limit);
               start = int'(free_ptr);
               res.index = free_ptr;
               res.ok    = 1'b1;
               held_key[start]   = key;
               held_valid[start] = 1'b1;
               found = 0;
               for (int v = 1; v <= n; v++) begin
                  c = (start + v) % n;
                  if (!found && !held_valid[c]) begin
                     free_ptr = c[3:0];
                     found    = 1;
                  end
               end
               if (!found) map_full = 1'b1;
            end
         end
         kra_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               held_valid[hit] = 1'b0;
               free_ptr  = hit[3:0];
               map_full  = 1'b0;
               res.index = hit[3:0];
               res.ok    = 1'b1;
            end
         end
         default: begin
            held_valid = '0;
            free_ptr   = 4'd0;
            map_full   = 1'b0;
            res.ok     = 1'b1;
         end
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance with
   // req_tvalid still high so back-to-back items need no extra assignment.
   task automatic send_item(input logic [kra_pkg::OP_W-1:0] op, input logic [31:0] key,
                            input bit typed, input logic [3:0] index, input logic ok);
      alloc_result_type res;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      predict_allocation(op, key, res);
      if (typed) begin
         res.index = index;
         res.ok    = ok;
      end
      pending_results.push_back(res);
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_count(input logic [kra_pkg::CFG_W-1:0] val);
      go_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= kra_pkg::CSR_ADDR_W'(kra_pkg::REG_IDX_COUNT) << 2;
      csr_pwdata  <= kra_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      reg_limit = val;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic add_row(input bit is_cfg, input logic [kra_pkg::CFG_W-1:0] count,
                          input logic [kra_pkg::OP_W-1:0] op, input logic [31:0] key,
                          input bit typed, input logic [3:0] index, input logic ok);
      step_row_type r;
      r.is_cfg = is_cfg;
      r.count  = count;
      r.op     = op;
      r.key    = key;
      r.typed  = typed;
      r.index  = index;
      r.ok     = ok;
      directed_steps.push_back(r);
   endtask

   initial begin
      logic [kra_pkg::CFG_W-1:0] phase_counts[PHASE_COUNT];
      logic [kra_pkg::OP_W-1:0]  op;
      logic [31:0]               key;
      int                        pool_size;
      int                        pick;
      int                        item_no;
      int                        total;

      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = kra_pkg::OP_LOOKUP;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      errors      = 0;
      cycles      = 0;
      stall_left  = 0;
      calm        = 0;
      held_valid  = '0;
      free_ptr    = 4'd0;
      map_full    = 1'b0;
      reg_limit   = kra_pkg::CFG_COUNT_RESET;
      for (int i = 0; i < NUM_REGS; i++) held_key[i] = '0;

      // Directed steps; typed expectations where the answer is obvious
      add_row(0, 0,  kra_pkg::OP_LOOKUP, 32'h0000_0000, 1, 4'd0, 1'b0);  // empty map
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0000, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0000, 1, 4'd0, 1'b0);  // already present
      add_row(0, 0,  kra_pkg::OP_ADD,    32'hFFFF_FFFF, 1, 4'd1, 1'b1);
      add_row(0, 0,  kra_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1, 4'd1, 1'b1);
      add_row(0, 0,  kra_pkg::OP_LOOKUP, 32'h0000_0000, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_REMOVE, 32'h0000_0000, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_REMOVE, 32'h0000_0000, 1, 4'd0, 1'b0);  // absent key
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h8000_0000, 0, 4'd0, 1'b0);
      add_row(0, 0,  kra_pkg::OP_CLEAR,  32'hAAAA_5555, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1, 4'd0, 1'b0);
      add_row(1, 0,  kra_pkg::OP_LOOKUP, 32'h0,         0, 4'd0, 1'b0);  // zero acts as one
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0001, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0002, 1, 4'd0, 1'b0);  // all taken
      add_row(1, 31, kra_pkg::OP_LOOKUP, 32'h0,         0, 4'd0, 1'b0);  // clamp to maximum
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0003, 1, 4'd0, 1'b0);  // full flag stays
      add_row(0, 0,  kra_pkg::OP_REMOVE, 32'h0000_0001, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0003, 1, 4'd0, 1'b1);
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0004, 0, 4'd0, 1'b0);
      add_row(1, 2,  kra_pkg::OP_LOOKUP, 32'h0,         0, 4'd0, 1'b0);  // shrink to the number held
      add_row(0, 0,  kra_pkg::OP_ADD,    32'h0000_0005, 0, 4'd0, 1'b0);
      add_row(0, 0,  kra_pkg::OP_LOOKUP, 32'h0000_0004, 0, 4'd0, 1'b0);
      add_row(0, 0,  kra_pkg::OP_CLEAR,  32'h5555_AAAA, 1, 4'd0, 1'b1);
      add_row(1, 16, kra_pkg::OP_LOOKUP, 32'h0,         0, 4'd0, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg)
            write_count(directed_steps[i].count);
         else
            send_item(directed_steps[i].op, directed_steps[i].key, directed_steps[i].typed,
                      directed_steps[i].index, directed_steps[i].ok);
      end

      phase_counts[0] = 5'd16;
      phase_counts[1] = 5'd1;
      phase_counts[2] = 5'd0;
      phase_counts[3] = 5'd31;
      phase_counts[4] = kra_pkg::CFG_W'($urandom_range(2, 15));
      phase_counts[5] = 5'd17;
      total   = PHASE_COUNT * PHASE_ITEMS;
      item_no = 0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_count(phase_counts[p]);
         // A pool a little larger than the register count makes the map fill up
         pool_size = effective_count(phase_counts[p]) + $urandom_range(1, 6);
         key_pool.delete();
         for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (item_no == total / 2) go_idle();
            if (item_no >= total - CALM_ITEMS) calm = 1;
            pick = $urandom_range(0, 99);
            key  = key_pool[$urandom_range(0, pool_size - 1)];
            if (pick < 10) begin
               op  = kra_pkg::OP_W'($urandom_range(0, 3));
               key = $urandom;
            end else if (pick < 45) begin
               op = kra_pkg::OP_ADD;
            end else if (pick < 70) begin
               op = kra_pkg::OP_LOOKUP;
            end else if (pick < 97) begin
               op = kra_pkg::OP_REMOVE;
            end else begin
               op = kra_pkg::OP_CLEAR;
            end
            send_item(op, key, 0, 4'd0, 1'b0);
            item_no++;
         end
      end

      go_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
